[rtl/rtc_pkg.sv]
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and constants for the radio telegram CRC-8 checker
// Telegram type table, default length, verdict codes and register indexes.
// ----------------------------------------------------------------------------
package rtc_pkg;

	localparam int unsigned TYPE_COUNT = 7;

	// length used for a type that is not in the table
	localparam logic [7:0] DEFAULT_LENGTH = 8'd32;
	// a fill of this many bytes or fewer is rejected as too few bytes
	localparam logic [7:0] MIN_FILL = 8'd3;

	localparam logic [7:0] POLY_RESET = 8'h2F;
	localparam logic [7:0] INIT_RESET = 8'hAA;

	localparam logic [7:0] TYPE_CODES [TYPE_COUNT] = '{
		8'h00, 8'h01, 8'h03, 8'h83, 8'hA3, 8'hE7, 8'h90
	};
	localparam logic [7:0] TYPE_LENGTHS [TYPE_COUNT] = '{
		8'd8, 8'd8, 8'd11, 8'd10, 8'd10, 8'd8, 8'd1
	};

	typedef enum logic [1:0] {
		VERDICT_ACCEPTED  = 2'd0,
		VERDICT_TOO_FEW   = 2'd1,
		VERDICT_SHORT     = 2'd2,
		VERDICT_CRC_ERROR = 2'd3
	} verdict_t;

	typedef enum logic {
		REG_CRC_POLYNOMIAL = 1'b0,
		REG_CRC_INIT       = 1'b1
	} reg_index_t;

	// map a telegram type to its expected length
	function automatic logic [7:0] type_length(input logic [7:0] t);
		logic [7:0] len;
		len = DEFAULT_LENGTH;
		for (int k = TYPE_COUNT - 1; k >= 0; k--) begin
			if (TYPE_CODES[k] == t) begin
				len = TYPE_LENGTHS[k];
			end
		end
		return len;
	endfunction

endpackage

[rtl/rtc_if.sv]
// ----------------------------------------------------------------------------
// rtc_if: valid/ready channels of the telegram checker
// Byte channel into the checker and verdict channel out of it.
// ----------------------------------------------------------------------------
interface rtc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       last_byte;

	modport source(output valid, output rx_byte, output last_byte, input ready);
	modport sink(input valid, input rx_byte, input last_byte, output ready);
endinterface

interface rtc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic [7:0] telegram_type;
	logic [7:0] expected_length;
	logic [7:0] computed_crc;

	modport source(output valid, output verdict, output telegram_type,
		output expected_length, output computed_crc, input ready);
	modport sink(input valid, input verdict, input telegram_type,
		input expected_length, input computed_crc, output ready);
endinterface

[rtl/rf_telegram_crc8_checker.sv]
// ----------------------------------------------------------------------------
// rf_telegram_crc8_checker: CRC-8 check of received radio telegrams
// Looks up the telegram length from the type byte, runs the CRC over the
// covered bytes, compares it with the check byte and gives a verdict on the
// byte flagged last.
// ----------------------------------------------------------------------------
// Path: an accepted last byte passes the input register, then the result
//   register, where its verdict becomes valid.
// Throughput: one byte per cycle unless a held verdict stalls; CRC step and
//   type lookup fit in the single stage from input register to telegram state.
// Reset: arst_n clears all valid flags and telegram state; polynomial returns
//   to 0x2F and init value to 0xAA.
module rf_telegram_crc8_checker (
	input  logic            clk,
	input  logic            arst_n,
	rtc_in_if.sink          rx,
	rtc_out_if.source       result,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [7:0]      cfg_wdata
);

	// configuration registers
	logic [7:0] crc_poly_q;
	logic [7:0] crc_init_q;

	// input stage
	logic       s1_valid_s1;
	logic [7:0] s1_byte_s1;
	logic       s1_last_s1;

	// telegram state
	logic [7:0] byte_index_q;
	logic [7:0] type_q;
	logic [7:0] len_q;
	logic [7:0] crc_q;
	logic       matched_q;
	logic       reached_q;

	// result register
	logic       res_valid_q;
	logic [1:0] res_verdict_q;
	logic [7:0] res_type_q;
	logic [7:0] res_len_q;
	logic [7:0] res_crc_q;

	logic       advance;
	logic       process;
	logic       pos_zero;
	logic [7:0] type_n;
	logic [7:0] len_n;
	logic [7:0] len_eff;
	logic [7:0] covered;
	logic [7:0] crc_base;
	logic [7:0] crc_stepped;
	logic [7:0] crc_n;
	logic       hit;
	logic       matched_n;
	logic       reached_n;
	logic [7:0] count;
	rtc_pkg::verdict_t verdict_n;

	// the stage moves whenever the result register is free or being drained
	assign advance = !res_valid_q || result.ready;
	assign process = s1_valid_s1 && advance;
	assign rx.ready = !s1_valid_s1 || advance;

	// configuration writes; an index outside the list does nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q <= rtc_pkg::POLY_RESET;
			crc_init_q <= rtc_pkg::INIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rtc_pkg::REG_CRC_POLYNOMIAL: crc_poly_q <= cfg_wdata;
				rtc_pkg::REG_CRC_INIT:       crc_init_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register: hold while the stage is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			s1_valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			s1_byte_s1 <= rx.rx_byte;
			s1_last_s1 <= rx.last_byte;
		end
	end

	// Byte zero captures the type, looks up its length and loads the CRC
	// from the init register.
	assign pos_zero = (byte_index_q == '0);
	assign type_n   = pos_zero ? s1_byte_s1 : type_q;
	assign len_n    = pos_zero ? rtc_pkg::type_length(s1_byte_s1) : len_q;
	assign crc_base = pos_zero ? crc_init_q : crc_q;

	// A length-one type still runs the CRC over byte zero and then checks
	// it against that same byte.
	assign len_eff = (len_n == '0) ? 8'd1 : len_n;
	assign covered = (len_eff > 8'd1) ? (len_eff - 8'd1) : 8'd1;

	rtc_crc8_step u_crc (
		.crc      (crc_base),
		.data     (s1_byte_s1),
		.poly     (crc_poly_q),
		.crc_next (crc_stepped)
	);

	assign crc_n     = (byte_index_q < covered) ? crc_stepped : crc_base;
	assign hit       = (byte_index_q == (len_eff - 8'd1));
	assign matched_n = hit ? (crc_n == s1_byte_s1) : matched_q;
	assign reached_n = hit || reached_q;

	// byte count saturates, so a long fill never looks short
	assign count = (byte_index_q == 8'hFF) ? 8'hFF : (byte_index_q + 8'd1);

	// verdict priority: too few bytes, then short telegram, then CRC
	always_comb begin
		if (count <= rtc_pkg::MIN_FILL) begin
			verdict_n = rtc_pkg::VERDICT_TOO_FEW;
		end else if ((count < len_eff) || !reached_n) begin
			verdict_n = rtc_pkg::VERDICT_SHORT;
		end else if (!matched_n) begin
			verdict_n = rtc_pkg::VERDICT_CRC_ERROR;
		end else begin
			verdict_n = rtc_pkg::VERDICT_ACCEPTED;
		end
	end

	// telegram state: advance on every byte, clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			type_q       <= '0;
			len_q        <= '0;
			crc_q        <= '0;
			matched_q    <= 1'b0;
			reached_q    <= 1'b0;
		end else if (process) begin
			if (s1_last_s1) begin
				byte_index_q <= '0;
				type_q       <= '0;
				len_q        <= '0;
				crc_q        <= '0;
				matched_q    <= 1'b0;
				reached_q    <= 1'b0;
			end else begin
				byte_index_q <= count;
				type_q       <= type_n;
				len_q        <= len_n;
				crc_q        <= crc_n;
				matched_q    <= matched_n;
				reached_q    <= reached_n;
			end
		end
	end

	// result register: load a verdict only on the last byte, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= process && s1_last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process && s1_last_s1) begin
			res_verdict_q <= verdict_n;
			res_type_q    <= type_n;
			res_len_q     <= len_n;
			res_crc_q     <= crc_n;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.verdict         = res_verdict_q;
	assign result.telegram_type   = res_type_q;
	assign result.expected_length = res_len_q;
	assign result.computed_crc    = res_crc_q;

	// a new verdict appears only after a last byte went through the stage
	a_verdict_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !$past(res_valid_q)) |-> $past(s1_valid_s1 && s1_last_s1))
		else $error("verdict without a last byte");

	// the last byte returns the byte position to zero
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(process && s1_last_s1) |=> (byte_index_q == '0))
		else $error("byte position not cleared after last byte");

	// an ordinary byte moves the position by one until saturation
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(process && !s1_last_s1 && (byte_index_q != 8'hFF))
		|=> (byte_index_q == $past(byte_index_q) + 8'd1))
		else $error("byte position did not advance");

	// without a processed byte the telegram state holds
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!process |=> ($stable(byte_index_q) && $stable(crc_q)))
		else $error("telegram state changed while idle");

endmodule

[rtl/rtc_crc8_step.sv]
// ----------------------------------------------------------------------------
// rtc_crc8_step: one byte of an MSB-first CRC-8
// Eight shift/xor steps unrolled; polynomial with implicit top bit.
// ----------------------------------------------------------------------------
module rtc_crc8_step (
	input  logic [7:0] crc,
	input  logic [7:0] data,
	input  logic [7:0] poly,
	output logic [7:0] crc_next
);

	logic [7:0] c;

	always_comb begin
		c = crc ^ data;
		for (int n = 0; n < 8; n++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

[bench/rf_telegram_crc8_checker_test.sv]
// ----------------------------------------------------------------------------
// rf_telegram_crc8_checker_test: self-checking bench for the telegram checker
// Feeds byte streams of radio telegrams through the valid/ready input, predicts
// each verdict with a model of the type table and the CRC-8, and compares every
// verdict transaction field by field under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module rf_telegram_crc8_checker_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Telegram rules of the predictor.
	localparam int unsigned KNOWN_COUNT  = 7;
	localparam logic [7:0]  FALLBACK_LEN = 8'd32;
	localparam int unsigned FEW_BYTES    = 3;
	localparam logic [7:0]  KNOWN_TYPES   [KNOWN_COUNT] = '{
		8'h00, 8'h01, 8'h03, 8'h83, 8'hA3, 8'hE7, 8'h90
	};
	localparam logic [7:0]  KNOWN_LENGTHS [KNOWN_COUNT] = '{
		8'd8, 8'd8, 8'd11, 8'd10, 8'd10, 8'd8, 8'd1
	};

	localparam int unsigned MAX_GAP       = 16;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned PHASE_BYTES   = 180;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} rx_byte_t;

	typedef struct packed {
		rtc_pkg::verdict_t verdict;
		logic [7:0]        ttype;
		logic [7:0]        length;
		logic [7:0]        crc;
	} verdict_rec_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	rtc_pkg::reg_index_t cfg_index;
	logic [7:0]          cfg_wdata;

	rtc_in_if  rx_ch ();
	rtc_out_if res_ch ();

	rf_telegram_crc8_checker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Bytes waiting to be offered, verdicts waiting to come out.
	rx_byte_t     bytes_to_send [$];
	verdict_rec_t verdicts_due  [$];
	int unsigned  bytes_queued = 0;
	int unsigned  error_count  = 0;

	// Register copies seen by the predictor.
	logic [7:0] poly_cfg = rtc_pkg::POLY_RESET;
	logic [7:0] init_cfg = rtc_pkg::INIT_RESET;

	// Predicted telegram state.
	logic [7:0] pos_q     = '0;
	logic [7:0] type_q    = '0;
	logic [7:0] len_q     = '0;
	logic [7:0] crc_q     = '0;
	bit         match_q   = 1'b0;
	bit         reached_q = 1'b0;

	// Idling control, written by the sequence only.
	bit          sender_gaps     = 1'b1;
	bit          receiver_stalls = 1'b1;
	int unsigned hold_requests   = 0;

	// ------------------------------------------------------------------------
	// Telegram arithmetic
	// ------------------------------------------------------------------------
	function automatic logic [7:0] telegram_length(input logic [7:0] t);
		for (int k = 0; k < KNOWN_COUNT; k++) begin
			if (KNOWN_TYPES[k] == t) begin
				return KNOWN_LENGTHS[k];
			end
		end
		return FALLBACK_LEN;
	endfunction

	// MSB-first CRC-8 over one byte, top bit of the polynomial implicit.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int n = 0; n < 8; n++) begin
			c = c[7] ? ((c << 1) ^ poly) : (c << 1);
		end
		return c;
	endfunction

	// Advance the predicted telegram by one accepted byte; on the last byte
	// queue the verdict and start over.
	function automatic void track_telegram_byte(input logic [7:0] b, input logic last);
		int unsigned  len;
		int unsigned  covered;
		int unsigned  count;
		verdict_rec_t v;
		if (pos_q == 0) begin
			type_q = b;
			len_q  = telegram_length(b);
			crc_q  = init_cfg;
		end
		len     = (len_q < 1) ? 1 : len_q;
		covered = (len > 1) ? len - 1 : 1;
		if (pos_q < covered) begin
			crc_q = crc8_step(crc_q, b, poly_cfg);
		end
		// a length-one type checks byte zero against its own CRC
		if (pos_q == len - 1) begin
			reached_q = 1'b1;
			match_q   = (crc_q == b);
		end
		// byte count saturates; trailing bytes past the check byte only count
		count = pos_q + 1;
		if (count > 255) begin
			count = 255;
		end
		pos_q = 8'(count);
		if (last) begin
			if (count <= FEW_BYTES) begin
				v.verdict = rtc_pkg::VERDICT_TOO_FEW;
			end else if (count < len || !reached_q) begin
				v.verdict = rtc_pkg::VERDICT_SHORT;
			end else if (!match_q) begin
				v.verdict = rtc_pkg::VERDICT_CRC_ERROR;
			end else begin
				v.verdict = rtc_pkg::VERDICT_ACCEPTED;
			end
			v.ttype  = type_q;
			v.length = len_q;
			v.crc    = crc_q;
			verdicts_due.push_back(v);
			pos_q     = '0;
			type_q    = '0;
			len_q     = '0;
			crc_q     = '0;
			match_q   = 1'b0;
			reached_q = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	// Queue one telegram of count bytes, type first. With seal set and L > 1,
	// place the correct check byte at L-1 (spoiled on request); rest is random.
	task automatic queue_telegram(input logic [7:0] ttype, input int unsigned count,
		input bit seal, input bit spoil);
		int unsigned len;
		logic [7:0]  crc;
		logic [7:0]  b;
		rx_byte_t    item;
		len = telegram_length(ttype);
		crc = init_cfg;
		for (int unsigned i = 0; i < count; i++) begin
			if (i == 0) begin
				b = ttype;
			end else if (seal && len > 1 && i == len - 1) begin
				b = spoil ? (crc ^ 8'($urandom_range(1, 255))) : crc;
			end else begin
				b = 8'($urandom_range(0, 255));
			end
			if (i < len - 1 || (len == 1 && i == 0)) begin
				crc = crc8_step(crc, b, poly_cfg);
			end
			item.data = b;
			item.last = (i == count - 1);
			bytes_to_send.push_back(item);
		end
		bytes_queued += count;
	endtask

	// Mostly well-formed telegrams with random content, the rest broken or noise.
	task automatic queue_random_telegram();
		int unsigned pick;
		int unsigned len;
		int unsigned count;
		logic [7:0]  t;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			if ($urandom_range(0, 4) == 0) begin
				do begin
					t = 8'($urandom_range(0, 255));
				end while (telegram_length(t) != FALLBACK_LEN);
			end else begin
				t = KNOWN_TYPES[$urandom_range(0, KNOWN_COUNT - 1)];
			end
			len = telegram_length(t);
			if (len == 1) begin
				count = $urandom_range(4, 8);
			end else begin
				count = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
			end
			queue_telegram(t, count, 1'b1, $urandom_range(0, 5) == 0);
		end else if (pick < 9) begin
			t   = KNOWN_TYPES[$urandom_range(0, KNOWN_COUNT - 1)];
			len = telegram_length(t);
			queue_telegram(t, $urandom_range(1, len + 2), 1'b0, 1'b0);
		end else begin
			queue_telegram(8'($urandom_range(0, 255)), $urandom_range(1, 6), 1'b0, 1'b0);
		end
	endtask

	// Hold until every byte is taken and every verdict is back, then let the
	// pipeline settle.
	task automatic wait_idle();
		do begin
			@(posedge clk);
		end while (bytes_to_send.size() != 0 || rx_ch.valid || verdicts_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input rtc_pkg::reg_index_t idx, input logic [7:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			rtc_pkg::REG_CRC_POLYNOMIAL: poly_cfg = value;
			rtc_pkg::REG_CRC_INIT:       init_cfg = value;
			default: ;
		endcase
	endtask

	task automatic set_crc_config(input logic [7:0] poly, input logic [7:0] init);
		write_register(rtc_pkg::REG_CRC_POLYNOMIAL, poly);
		write_register(rtc_pkg::REG_CRC_INIT, init);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic fill_random_phase();
		bytes_queued = 0;
		while (bytes_queued < PHASE_BYTES) begin
			queue_random_telegram();
		end
	endtask

	task automatic flag_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
		end
	endtask

	// ------------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Byte driver: offer queued bytes, predict on each accepted transaction,
	// then leave a random gap before the next offer.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : byte_driver
		int unsigned send_gap;
		rx_byte_t    item;
		if (!arst_n) begin
			rx_ch.valid     <= 1'b0;
			rx_ch.rx_byte   <= '0;
			rx_ch.last_byte <= 1'b0;
			send_gap = 0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				track_telegram_byte(rx_ch.rx_byte, rx_ch.last_byte);
				send_gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
			end
			// hold the current byte while the checker stalls its input
			if (!rx_ch.valid || rx_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					rx_ch.valid <= 1'b0;
				end else if (bytes_to_send.size() != 0) begin
					item = bytes_to_send.pop_front();
					rx_ch.rx_byte   <= item.data;
					rx_ch.last_byte <= item.last;
					rx_ch.valid     <= 1'b1;
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Verdict monitor: check each accepted transaction against the oldest
	// prediction, stall at random, and serve long hold-off requests.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : verdict_monitor
		int unsigned  stall;
		int unsigned  hold_left;
		int unsigned  hold_served;
		verdict_rec_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall       = 0;
			hold_left   = 0;
			hold_served = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (verdicts_due.size() == 0) begin
					error_count++;
					$display("%0t: verdict transaction with none expected: actual %0d",
						$time, res_ch.verdict);
				end else begin
					want = verdicts_due.pop_front();
					flag_field("verdict", want.verdict, res_ch.verdict);
					flag_field("telegram_type", want.ttype, res_ch.telegram_type);
					flag_field("expected_length", want.length, res_ch.expected_length);
					flag_field("computed_crc", want.crc, res_ch.computed_crc);
				end
				stall = receiver_stalls ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (hold_left == 0 && hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run if it never drains.
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		// drive the reset and configuration inputs from time zero
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = rtc_pkg::REG_CRC_POLYNOMIAL;
		cfg_wdata       = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// Directed part, reset register values.
		// single byte of an unknown type: too few bytes
		queue_telegram(8'hFF, 1, 1'b0, 1'b0);
		// three bytes, the largest fill still rejected as too few
		queue_telegram(8'h00, 3, 1'b0, 1'b0);
		// length-one type: byte zero is checked against its own CRC
		queue_telegram(8'h90, 4, 1'b0, 1'b0);
		// sealed telegram plus one trailing byte past the check byte
		queue_telegram(8'h00, 9, 1'b1, 1'b0);
		// short telegram: partial CRC reported
		queue_telegram(8'h03, 5, 1'b0, 1'b0);
		wait_idle();

		// Low extremes of both registers, full idling on both sides.
		set_crc_config(8'h00, 8'h00);
		fill_random_phase();
		wait_idle();

		// High extremes; drop all idling and hold the receiver off for a long
		// stretch so the checker fills up and stalls its input.
		set_crc_config(8'hFF, 8'hFF);
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		hold_requests++;
		for (int n = 0; n < 40; n++) begin
			queue_telegram(KNOWN_TYPES[$urandom_range(0, KNOWN_COUNT - 2)],
				$urandom_range(8, 11), 1'b1, $urandom_range(0, 5) == 0);
		end
		wait_idle();

		// Random registers, sender gaps only.
		set_crc_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		sender_gaps = 1'b1;
		fill_random_phase();
		wait_idle();

		// Receiver stalls only.
		set_crc_config(8'h07, 8'h55);
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b1;
		fill_random_phase();
		wait_idle();

		// Random registers, both sides idling, two very long telegrams so the
		// byte count saturates.
		set_crc_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		sender_gaps = 1'b1;
		queue_telegram(KNOWN_TYPES[$urandom_range(0, KNOWN_COUNT - 1)], 260, 1'b1, 1'b0);
		fill_random_phase();
		queue_telegram(8'hC5, 300, 1'b1, 1'b0);
		wait_idle();

		// Back to the reset values with random traffic.
		set_crc_config(rtc_pkg::POLY_RESET, rtc_pkg::INIT_RESET);
		fill_random_phase();
		wait_idle();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && verdicts_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/rtc_pkg.sv
rtl/rtc_if.sv
rtl/rtc_crc8_step.sv
rtl/rf_telegram_crc8_checker.sv
bench/rf_telegram_crc8_checker_test.sv
